/* src/double_ended_queue_unit_macros.svh */
// assertion macros for the double-ended queue unit
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define DQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/dq_pkg.sv */
// shared types, constants and index helpers for the double-ended queue
package dq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = 7;
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_PEEK_BACK  = 3'd4,
    OP_PEEK_FRONT = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_t          status;
    logic             has_data;
    logic [CNT_W-1:0] occupancy;
  } res_t;

  function automatic logic [ADDR_W-1:0] idx_inc(input logic [ADDR_W-1:0] idx);
    logic [ADDR_W-1:0] r;
    if (idx == ADDR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = idx + ADDR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] idx_dec(input logic [ADDR_W-1:0] idx);
    logic [ADDR_W-1:0] r;
    if (idx == '0) begin
      r = ADDR_W'(DEPTH - 1);
    end else begin
      r = idx - ADDR_W'(1);
    end
    return r;
  endfunction

endpackage

/* src/dq_ram.sv */
// element store: one write port, one registered read port
module dq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/dq_ptr.sv */
// front/back indices and element count, decodes each op into a memory access
module dq_ptr import dq_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            issue,
  input  logic [OP_W-1:0] op,
  output mem_req_t        req,
  output res_t            res
);

  logic [ADDR_W-1:0] front_r, front_nxt;
  logic [ADDR_W-1:0] back_r, back_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              empty, full;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));

  always_comb begin
    front_nxt    = front_r;
    back_nxt     = back_r;
    count_nxt    = count_r;
    req          = '0;
    res.status   = ST_DONE;
    res.has_data = 1'b0;
    case (op)
      OP_PUSH_BACK: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          req.we    = issue;
          req.waddr = back_r;
          back_nxt  = idx_inc(back_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          req.we    = issue;
          req.waddr = idx_dec(front_r);
          front_nxt = idx_dec(front_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          req.re       = issue;
          req.raddr    = idx_dec(back_r);
          res.has_data = 1'b1;
          if (op == OP_POP_BACK) begin
            back_nxt  = idx_dec(back_r);
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          req.re       = issue;
          req.raddr    = front_r;
          res.has_data = 1'b1;
          if (op == OP_POP_FRONT) begin
            front_nxt = idx_inc(front_r);
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    res.occupancy = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (issue) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* src/double_ended_queue_unit.sv */
// top level of the bounded double-ended queue (ring buffer in one ram)
//
// usage:
//   drive in_op and in_push_data with start high; the op is taken at a rising
//   edge where start is high and busy is low. busy stays low, so one op can be
//   issued every cycle.
//   ops: push back/front, pop back/front, peek back/front.
//   each op gives one result word: out_valid is high for exactly one cycle,
//   the cycle right after the op was taken, with out_read_data, out_status
//   and out_occupancy (elements held after the op).
//   throughput is one op per cycle: indices and count update at the accept
//   edge, and the ram's registered read port returns the popped or peeked
//   word in the next cycle.
//   a push on a full queue is dropped with status full; a pop or peek on an
//   empty queue returns zero with status empty.
//   the receiver cannot hold results off, so nothing stalls.
//   synchronous reset empties the queue (indices and count to zero) and
//   clears out_valid; stored words are left as they are.
module double_ended_queue_unit import dq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       in_op,
  input  logic [DATA_WIDTH-1:0] in_push_data,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] out_read_data,
  output logic [STATUS_W-1:0]   out_status,
  output logic [CNT_W-1:0]      out_occupancy
);

`include "double_ended_queue_unit_macros.svh"

  logic                  accept;
  mem_req_t              req;
  res_t                  res;
  logic [DATA_WIDTH-1:0] rd_data;

  logic                  out_valid_r;
  status_t               status_r;
  logic                  has_data_r;
  logic [CNT_W-1:0]      occ_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  dq_ptr u_ptr (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (accept),
    .op    (in_op),
    .req   (req),
    .res   (res)
  );

  dq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_WIDTH),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (in_push_data),
    .re    (req.re),
    .raddr (req.raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  // result word fields, paired with the ram read issued at the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r   <= res.status;
      has_data_r <= res.has_data;
      occ_r      <= res.occupancy;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = has_data_r ? rd_data : '0;
  assign out_status    = status_r;
  assign out_occupancy = occ_r;

  `DQ_ASSERT_NEXT(a_result_follows, accept, out_valid, "accepted op gave no result word")
  `DQ_ASSERT_NEXT(a_no_spurious, !accept, !out_valid, "result word without an accepted op")
  `DQ_ASSERT_NOW(a_full_occ, out_valid && (out_status == ST_FULL), out_occupancy == CNT_W'(DEPTH), "full status with queue not full")
  `DQ_ASSERT_NOW(a_empty_zero, out_valid && (out_status == ST_EMPTY), (out_occupancy == '0) && (out_read_data == '0), "empty status with data or occupancy")

endmodule
